FILE: design/qbmv_pkg.sv
// ----------------------------------------------------------------------------
// qbmv_pkg
// shared widths, codes and controller/datapath interface types for the block
// mean and variance unit
// ----------------------------------------------------------------------------
package qbmv_pkg;

  localparam int MANT_W     = 16;
  localparam int ACC_W      = 32;
  localparam int SQ_W       = 47;
  localparam int CNT_W      = 17;
  localparam int COUNT_W    = 16;
  localparam int MBITS_W    = 5;
  localparam int SCALE_W    = 32;
  localparam int MEAN_W     = 48;
  localparam int VAR_W      = 63;
  localparam int MAX_MBITS  = 16;
  localparam int CAP_LOG    = 16;
  localparam int SCALE_FRAC = 24;
  localparam int FRAC_OUT   = 16;
  localparam int MEAN_SHIFT = SCALE_FRAC - FRAC_OUT;
  localparam int VAR_SHIFT  = 2 * SCALE_FRAC - FRAC_OUT;
  localparam int OPND_W     = 32;
  localparam int PROD_W     = 2 * OPND_W;
  localparam int ACCUM_W    = 4 * OPND_W;
  localparam int DVS_W      = 32;
  localparam int DIV_W      = ACCUM_W - 2 - VAR_SHIFT;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MBITS = 2'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0100_0000;
  localparam logic [MBITS_W-1:0] MBITS_RESET = 5'd16;

  typedef enum logic [2:0] {
    A_MAG,
    A_SCALE,
    A_N,
    A_S2LO,
    A_S2HI
  } a_sel_t;

  typedef enum logic [2:0] {
    B_SCALE,
    B_MAG,
    B_SUMSQ_LO,
    B_SUMSQ_HI,
    B_N,
    B_DLO,
    B_DHI
  } b_sel_t;

  typedef enum logic {
    DIV_MEAN,
    DIV_VAR
  } div_sel_t;

  typedef struct packed {
    logic       take_in;
    logic       mul_en;
    a_sel_t     a_sel;
    b_sel_t     b_sel;
    logic       acc_en;
    logic       acc_clr;
    logic       acc_sub;
    logic [1:0] acc_sh;
    logic       ld_s2;
    logic       ld_d;
    logic       ld_nn;
    logic       div_start;
    div_sel_t   div_sel;
    logic       ld_mean;
    logic       ld_var;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic flag;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

FILE: design/quantized_block_mean_variance.sv
// ----------------------------------------------------------------------------
// quantized_block_mean_variance
// streaming block mean and biased variance of quantized mantissas
//
// channel | dir | handshake          | payload
// in_     | in  | in_valid/in_stall   | in_mantissa, in_last
// out_    | out | out_valid/out_stall | out_mean_value, out_variance_value,
//         |     |                     | out_element_count, out_too_many
// cfg_    | in  | cfg_wr_en           | cfg_index, cfg_wr_data
//
// one element per cycle is taken while a block accumulates
// after the last element the input stalls until the result loads: a 12-step
// sequence on the shared 32x32 multiplier overlapping the first of two divides
// a block that hits the count bound skips the arithmetic
// the output register lets the next block accumulate while a result waits
// synchronous active-low reset; a result only loads once the register is free
// ----------------------------------------------------------------------------
module quantized_block_mean_variance (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [qbmv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qbmv_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [qbmv_pkg::MANT_W-1:0]  in_mantissa,
  input  logic                                in_last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [qbmv_pkg::MEAN_W-1:0]  out_mean_value,
  output logic [qbmv_pkg::VAR_W-1:0]          out_variance_value,
  output logic [qbmv_pkg::COUNT_W-1:0]        out_element_count,
  output logic                                out_too_many
);

  qbmv_pkg::cmd_t cmd;
  qbmv_pkg::sts_t sts;

  qbmv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  qbmv_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wr_data        (cfg_wr_data),
    .in_mantissa        (in_mantissa),
    .out_stall          (out_stall),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_mean_value     (out_mean_value),
    .out_variance_value (out_variance_value),
    .out_element_count  (out_element_count),
    .out_too_many       (out_too_many)
  );

endmodule

FILE: design/qbmv_div.sv
// ----------------------------------------------------------------------------
// qbmv_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module qbmv_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qbmv_pkg::DIV_W-1:0]  dividend,
  input  logic [qbmv_pkg::DVS_W-1:0]  divisor,
  output logic                        busy,
  output logic [qbmv_pkg::DIV_W-1:0]  quotient
);

  localparam int CNT_BITS = $clog2(qbmv_pkg::DIV_W);

  logic [qbmv_pkg::DIV_W-1:0] quo_r;
  logic [qbmv_pkg::DVS_W-1:0] rem_r;
  logic [qbmv_pkg::DVS_W-1:0] dvs_r;
  logic [CNT_BITS-1:0]        cnt_r;
  logic                       busy_r;

  logic [qbmv_pkg::DVS_W:0]   rem_sh;
  logic [qbmv_pkg::DVS_W:0]   rem_dif;
  logic                       ge;

  assign rem_sh  = {rem_r, quo_r[qbmv_pkg::DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_dif = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_BITS'(qbmv_pkg::DIV_W - 1);
      quo_r  <= dividend;
      rem_r  <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[qbmv_pkg::DIV_W-2:0], ge};
      rem_r <= ge ? rem_dif[qbmv_pkg::DVS_W-1:0] : rem_sh[qbmv_pkg::DVS_W-1:0];
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

FILE: design/qbmv_dp.sv
// ----------------------------------------------------------------------------
// qbmv_dp
// datapath: config registers, block accumulators, shared 32x32 multiplier
// with 128-bit accumulator, divider and output register
// ----------------------------------------------------------------------------
module qbmv_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [qbmv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qbmv_pkg::CFG_DATA_W-1:0]      cfg_wr_data,
  input  logic signed [qbmv_pkg::MANT_W-1:0]   in_mantissa,
  input  logic                                 out_stall,
  input  qbmv_pkg::cmd_t                       cmd,
  output qbmv_pkg::sts_t                       sts,
  output logic                                 out_valid,
  output logic signed [qbmv_pkg::MEAN_W-1:0]   out_mean_value,
  output logic [qbmv_pkg::VAR_W-1:0]           out_variance_value,
  output logic [qbmv_pkg::COUNT_W-1:0]         out_element_count,
  output logic                                 out_too_many
);

  logic [qbmv_pkg::SCALE_W-1:0]  scale_r;
  logic [qbmv_pkg::MBITS_W-1:0]  mbits_r;
  logic [qbmv_pkg::ACC_W-1:0]    sum_r;
  logic [qbmv_pkg::SQ_W-1:0]     sumsq_r;
  logic [qbmv_pkg::CNT_W-1:0]    cnt_r;
  logic                          flag_r;

  logic [qbmv_pkg::PROD_W-1:0]   prod_r;
  logic [qbmv_pkg::ACCUM_W-1:0]  acc_r;
  logic [qbmv_pkg::PROD_W-1:0]   s2_r;
  logic [qbmv_pkg::PROD_W-1:0]   d_r;
  logic [qbmv_pkg::OPND_W-1:0]   nn_r;
  logic [qbmv_pkg::MEAN_W-1:0]   mean_r;
  logic [qbmv_pkg::VAR_W-1:0]    var_r;

  logic                          out_valid_r;
  logic [qbmv_pkg::MEAN_W-1:0]   out_mean_r;
  logic [qbmv_pkg::VAR_W-1:0]    out_var_r;
  logic [qbmv_pkg::COUNT_W-1:0]  out_cnt_r;
  logic                          out_flag_r;

  // accumulation
  logic [qbmv_pkg::MBITS_W-1:0]  w_eff;
  logic [5:0]                    bound_exp;
  logic [qbmv_pkg::CNT_W-1:0]    cnt_nxt;
  logic                          bound_hit;
  logic                          flag_nxt;
  logic signed [31:0]            sq_full;

  always_comb begin
    if (mbits_r == '0) begin
      w_eff = qbmv_pkg::MBITS_W'(1);
    end else if (mbits_r > qbmv_pkg::MBITS_W'(qbmv_pkg::MAX_MBITS)) begin
      w_eff = qbmv_pkg::MBITS_W'(qbmv_pkg::MAX_MBITS);
    end else begin
      w_eff = mbits_r;
    end
    bound_exp = 6'(qbmv_pkg::ACC_W) - {1'b0, w_eff};
    cnt_nxt   = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
    if (bound_exp >= 6'(qbmv_pkg::CAP_LOG)) begin
      bound_hit = cnt_nxt[qbmv_pkg::CAP_LOG];
    end else begin
      bound_hit = cnt_nxt >= (qbmv_pkg::CNT_W'(1) << bound_exp);
    end
    flag_nxt = flag_r | bound_hit;
    sq_full  = 32'(in_mantissa) * 32'(in_mantissa);
  end

  // block magnitude and count
  logic                          neg;
  logic [qbmv_pkg::OPND_W-1:0]   mag;
  logic [qbmv_pkg::COUNT_W-1:0]  n;

  assign neg = sum_r[qbmv_pkg::ACC_W-1];
  assign mag = neg ? (~sum_r + 1'b1) : sum_r;
  assign n   = cnt_r[qbmv_pkg::COUNT_W-1:0];

  // multiplier operands
  logic [qbmv_pkg::OPND_W-1:0] a_val;
  logic [qbmv_pkg::OPND_W-1:0] b_val;

  always_comb begin
    case (cmd.a_sel)
      qbmv_pkg::A_MAG:   a_val = mag;
      qbmv_pkg::A_SCALE: a_val = scale_r;
      qbmv_pkg::A_N:     a_val = qbmv_pkg::OPND_W'(n);
      qbmv_pkg::A_S2LO:  a_val = s2_r[qbmv_pkg::OPND_W-1:0];
      qbmv_pkg::A_S2HI:  a_val = s2_r[qbmv_pkg::PROD_W-1:qbmv_pkg::OPND_W];
      default:           a_val = '0;
    endcase
    case (cmd.b_sel)
      qbmv_pkg::B_SCALE:    b_val = scale_r;
      qbmv_pkg::B_MAG:      b_val = mag;
      qbmv_pkg::B_SUMSQ_LO: b_val = sumsq_r[qbmv_pkg::OPND_W-1:0];
      qbmv_pkg::B_SUMSQ_HI: b_val = qbmv_pkg::OPND_W'(sumsq_r[qbmv_pkg::SQ_W-1:qbmv_pkg::OPND_W]);
      qbmv_pkg::B_N:        b_val = qbmv_pkg::OPND_W'(n);
      qbmv_pkg::B_DLO:      b_val = d_r[qbmv_pkg::OPND_W-1:0];
      qbmv_pkg::B_DHI:      b_val = d_r[qbmv_pkg::PROD_W-1:qbmv_pkg::OPND_W];
      default:              b_val = '0;
    endcase
  end

  // accumulator term, shifted by whole 32-bit words
  logic [qbmv_pkg::ACCUM_W-1:0] acc_term;
  logic [qbmv_pkg::ACCUM_W-1:0] acc_base;

  always_comb begin
    case (cmd.acc_sh)
      2'd0:    acc_term = {64'b0, prod_r};
      2'd1:    acc_term = {32'b0, prod_r, 32'b0};
      default: acc_term = {prod_r, 64'b0};
    endcase
    acc_base = cmd.acc_clr ? '0 : acc_r;
  end

  // divider
  logic [qbmv_pkg::DIV_W-1:0] div_dividend;
  logic [qbmv_pkg::DVS_W-1:0] div_divisor;
  logic                       div_busy;
  logic [qbmv_pkg::DIV_W-1:0] div_quo;

  always_comb begin
    case (cmd.div_sel)
      qbmv_pkg::DIV_MEAN: begin
        div_dividend = qbmv_pkg::DIV_W'(acc_r[qbmv_pkg::PROD_W-1:qbmv_pkg::MEAN_SHIFT]);
        div_divisor  = qbmv_pkg::DVS_W'(n);
      end
      default: begin
        div_dividend = acc_r[qbmv_pkg::VAR_SHIFT +: qbmv_pkg::DIV_W];
        div_divisor  = nn_r;
      end
    endcase
  end

  qbmv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  logic var_sat;
  assign var_sat = |div_quo[qbmv_pkg::DIV_W-1:qbmv_pkg::VAR_W];

  // control and block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= qbmv_pkg::SCALE_RESET;
      mbits_r     <= qbmv_pkg::MBITS_RESET;
      sum_r       <= '0;
      sumsq_r     <= '0;
      cnt_r       <= '0;
      flag_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          qbmv_pkg::CFG_SCALE: scale_r <= cfg_wr_data[qbmv_pkg::SCALE_W-1:0];
          qbmv_pkg::CFG_MBITS: mbits_r <= cfg_wr_data[qbmv_pkg::MBITS_W-1:0];
          default: ;
        endcase
      end
      if (cmd.out_load) begin
        sum_r   <= '0;
        sumsq_r <= '0;
        cnt_r   <= '0;
        flag_r  <= 1'b0;
      end else if (cmd.take_in) begin
        cnt_r  <= cnt_nxt;
        flag_r <= flag_nxt;
        if (!flag_nxt) begin
          sum_r   <= sum_r + qbmv_pkg::ACC_W'(in_mantissa);
          sumsq_r <= sumsq_r + qbmv_pkg::SQ_W'(sq_full[30:0]);
        end
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // arithmetic payload
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= a_val * b_val;
    end
    if (cmd.acc_en) begin
      acc_r <= cmd.acc_sub ? acc_base - acc_term : acc_base + acc_term;
    end
    if (cmd.ld_s2) begin
      s2_r <= prod_r;
    end
    if (cmd.ld_d) begin
      d_r <= acc_r[qbmv_pkg::PROD_W-1:0];
    end
    if (cmd.ld_nn) begin
      nn_r <= prod_r[qbmv_pkg::OPND_W-1:0];
    end
    if (cmd.ld_mean) begin
      mean_r <= neg ? (~div_quo[qbmv_pkg::MEAN_W-1:0] + 1'b1) : div_quo[qbmv_pkg::MEAN_W-1:0];
    end
    if (cmd.ld_var) begin
      var_r <= var_sat ? '1 : div_quo[qbmv_pkg::VAR_W-1:0];
    end
    if (cmd.out_load) begin
      out_mean_r <= flag_r ? '0 : mean_r;
      out_var_r  <= flag_r ? '0 : var_r;
      out_cnt_r  <= cnt_r[qbmv_pkg::CAP_LOG] ? '1 : n;
      out_flag_r <= flag_r;
    end
  end

  assign sts.flag     = flag_r;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign out_mean_value     = out_mean_r;
  assign out_variance_value = out_var_r;
  assign out_element_count  = out_cnt_r;
  assign out_too_many       = out_flag_r;

endmodule

FILE: design/qbmv_ctrl.sv
// ----------------------------------------------------------------------------
// qbmv_ctrl
// controller: element intake, multiply/accumulate step sequence, divider
// hand-off and result load
// ----------------------------------------------------------------------------
module qbmv_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last,
  input  qbmv_pkg::sts_t sts,
  output logic           in_stall,
  output qbmv_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_ACCUM,
    ST_CHECK,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_M8,
    ST_M9,
    ST_M10,
    ST_M11,
    ST_WMEAN,
    ST_WVAR,
    ST_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_stall_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_ACCUM: begin
        cmd.take_in = in_valid;
        if (in_valid && in_last) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = sts.flag ? ST_OUT : ST_M0;
      end
      // mean numerator
      ST_M0: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = qbmv_pkg::A_MAG;
        cmd.b_sel  = qbmv_pkg::B_SCALE;
        state_nxt  = ST_M1;
      end
      ST_M1: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.a_sel   = qbmv_pkg::A_SCALE;
        cmd.b_sel   = qbmv_pkg::B_SCALE;
        state_nxt   = ST_M2;
      end
      ST_M2: begin
        cmd.ld_s2     = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = qbmv_pkg::DIV_MEAN;
        cmd.mul_en    = 1'b1;
        cmd.a_sel     = qbmv_pkg::A_N;
        cmd.b_sel     = qbmv_pkg::B_SUMSQ_LO;
        state_nxt     = ST_M3;
      end
      // n * sumsq - sum^2
      ST_M3: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.a_sel   = qbmv_pkg::A_N;
        cmd.b_sel   = qbmv_pkg::B_SUMSQ_HI;
        state_nxt   = ST_M4;
      end
      ST_M4: begin
        cmd.acc_en = 1'b1;
        cmd.acc_sh = 2'd1;
        cmd.mul_en = 1'b1;
        cmd.a_sel  = qbmv_pkg::A_MAG;
        cmd.b_sel  = qbmv_pkg::B_MAG;
        state_nxt  = ST_M5;
      end
      ST_M5: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_sub = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.a_sel   = qbmv_pkg::A_N;
        cmd.b_sel   = qbmv_pkg::B_N;
        state_nxt   = ST_M6;
      end
      ST_M6: begin
        cmd.ld_d  = 1'b1;
        cmd.ld_nn = 1'b1;
        state_nxt = ST_M7;
      end
      // scale^2 * d as four partial products
      ST_M7: begin
        cmd.mul_en = 1'b1;
        cmd.a_sel  = qbmv_pkg::A_S2LO;
        cmd.b_sel  = qbmv_pkg::B_DLO;
        state_nxt  = ST_M8;
      end
      ST_M8: begin
        cmd.acc_en  = 1'b1;
        cmd.acc_clr = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.a_sel   = qbmv_pkg::A_S2LO;
        cmd.b_sel   = qbmv_pkg::B_DHI;
        state_nxt   = ST_M9;
      end
      ST_M9: begin
        cmd.acc_en = 1'b1;
        cmd.acc_sh = 2'd1;
        cmd.mul_en = 1'b1;
        cmd.a_sel  = qbmv_pkg::A_S2HI;
        cmd.b_sel  = qbmv_pkg::B_DLO;
        state_nxt  = ST_M10;
      end
      ST_M10: begin
        cmd.acc_en = 1'b1;
        cmd.acc_sh = 2'd1;
        cmd.mul_en = 1'b1;
        cmd.a_sel  = qbmv_pkg::A_S2HI;
        cmd.b_sel  = qbmv_pkg::B_DHI;
        state_nxt  = ST_M11;
      end
      ST_M11: begin
        cmd.acc_en = 1'b1;
        cmd.acc_sh = 2'd2;
        state_nxt  = ST_WMEAN;
      end
      ST_WMEAN: begin
        if (!sts.div_busy) begin
          cmd.ld_mean   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = qbmv_pkg::DIV_VAR;
          state_nxt     = ST_WVAR;
        end
      end
      ST_WVAR: begin
        cmd.div_sel = qbmv_pkg::DIV_VAR;
        if (!sts.div_busy) begin
          cmd.ld_var = 1'b1;
          state_nxt  = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_ACCUM;
        end
      end
      default: begin
        state_nxt = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_ACCUM;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= state_nxt != ST_ACCUM;
    end
  end

  assign in_stall = in_stall_r;

endmodule
